FILE: sv/sfh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfh_pkg: shared types and round functions of the byte-stream hash
// Holds the field widths, the tail record handed to the finishing pipeline
// and the mixing, tail and avalanche steps of the 32-bit hash.
// ----------------------------------------------------------------------------
package sfh_pkg;

  localparam int KeyLenW           = 16;
  localparam int HashW             = 32;
  localparam int LengthBitsDefault = 16;

  // record of a finished key, handed to the finishing pipeline
  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [23:0]      bytes;
    logic [1:0]       pend;
    logic             len_err;
    logic             empty;
  } sfh_tail_t;

  // sign-extend one tail byte
  function automatic logic [HashW-1:0] sext8(input logic [7:0] b);
    sext8 = {{(HashW-8){b[7]}}, b};
  endfunction

  // one mixing round over a full 4-byte group
  function automatic logic [HashW-1:0] mix_group(input logic [HashW-1:0] h_in,
                                                 input logic [15:0]      lo16,
                                                 input logic [15:0]      hi16);
    logic [HashW-1:0] h;
    logic [HashW-1:0] t;
    h = h_in + {16'd0, lo16};
    t = ({16'd0, hi16} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    mix_group = h;
  endfunction

  // fold the 1, 2 or 3 pending bytes into the hash
  function automatic logic [HashW-1:0] fold_tail(input logic [HashW-1:0] h_in,
                                                 input logic [1:0]       pend,
                                                 input logic [23:0]      bytes);
    logic [HashW-1:0] h;
    h = h_in;
    unique case (pend)
      2'd3: begin
        h = h + {16'd0, bytes[15:0]};
        h = h ^ (h << 16);
        h = h ^ (sext8(bytes[23:16]) << 18);
        h = h + (h >> 11);
      end
      2'd2: begin
        h = h + {16'd0, bytes[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      2'd1: begin
        h = h + sext8(bytes[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: begin
        h = h_in;
      end
    endcase
    fold_tail = h;
  endfunction

  // avalanche, first three steps
  function automatic logic [HashW-1:0] aval_a(input logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    aval_a = h;
  endfunction

  // avalanche, steps four and five
  function automatic logic [HashW-1:0] aval_b(input logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in + (h_in >> 17);
    h = h ^ (h << 25);
    aval_b = h;
  endfunction

  // avalanche, last step
  function automatic logic [HashW-1:0] aval_c(input logic [HashW-1:0] h_in);
    aval_c = h_in + (h_in >> 6);
  endfunction

endpackage

FILE: sv/superfast_byte_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// superfast_byte_hash: streaming 32-bit hash of a byte key
// Gathers key bytes into 4-byte groups, mixes each group into the running
// hash and finishes the key with tail folding and avalanche.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one key byte per
//   transfer with first and last marks; the first byte also carries the
//   declared key length, which seeds the hash.
//   Output channel (out_valid_o / out_stall_i) carries one hash and a
//   length-error flag per key, after the transfer of its last byte.
//   Throughput: one byte per cycle unless stalled; keys may follow each other
//   back to back. Group mixing happens in the cycle a byte is taken.
//   Finishing: the tail fold stage loads at the last byte's transfer and
//   three avalanche stages follow, the last one being the output register.
//   Stall: a stalled result holds in the output register; the finishing
//   pipeline keeps filling its empty stages and stalls the input only when
//   every stage holds a key and the output is stalled.
//   Reset: clears the running state and all pipeline valid bits; no result
//   is pending and a byte with no first mark starts from a zero state.
// ----------------------------------------------------------------------------
module superfast_byte_hash #(
  parameter int LENGTH_BITS = sfh_pkg::LengthBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    key_byte_i,
  input  logic [sfh_pkg::KeyLenW-1:0]   key_length_i,
  input  logic                          first_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sfh_pkg::HashW-1:0]     hash_value_o,
  output logic                          length_error_o
);

  logic [sfh_pkg::HashW-1:0]  hash_q, hash_d;
  logic [23:0]                bytes_q, bytes_d;
  logic [1:0]                 pos_q, pos_d;
  logic [LENGTH_BITS-1:0]     count_q, count_d;
  logic [LENGTH_BITS-1:0]     decl_q, decl_d;

  logic [LENGTH_BITS-1:0]     len_w;
  logic [sfh_pkg::HashW-1:0]  base_hash;
  logic [23:0]                base_bytes;
  logic [1:0]                 base_pos;
  logic [LENGTH_BITS-1:0]     base_count;
  logic [sfh_pkg::HashW-1:0]  next_hash;
  logic [23:0]                next_bytes;
  logic [1:0]                 next_pos;
  logic [LENGTH_BITS-1:0]     next_count;

  logic                       accept;
  logic                       fin_ready;
  logic                       tail_valid;
  sfh_pkg::sfh_tail_t         tail;

  // declared length fitted to the counter width
  if (LENGTH_BITS <= sfh_pkg::KeyLenW) begin : g_len_trunc
    assign len_w = key_length_i[LENGTH_BITS-1:0];
  end else begin : g_len_ext
    assign len_w = {{(LENGTH_BITS-sfh_pkg::KeyLenW){1'b0}}, key_length_i};
  end

  assign in_stall_o = !fin_ready;
  assign accept     = in_valid_i && !in_stall_o;

  // a first mark restarts the key from the declared length
  always_comb begin
    base_hash  = first_byte_i ? sfh_pkg::HashW'(len_w) : hash_q;
    base_bytes = first_byte_i ? '0 : bytes_q;
    base_pos   = first_byte_i ? '0 : pos_q;
    base_count = first_byte_i ? '0 : count_q;
    decl_d     = first_byte_i ? len_w : decl_q;
  end

  // byte gathering and group mixing
  always_comb begin
    next_count = base_count + LENGTH_BITS'(1);
    next_hash  = base_hash;
    next_bytes = base_bytes;
    next_pos   = base_pos + 2'd1;
    unique case (base_pos)
      2'd0: next_bytes[7:0]   = key_byte_i;
      2'd1: next_bytes[15:8]  = key_byte_i;
      2'd2: next_bytes[23:16] = key_byte_i;
      default: begin
        next_hash  = sfh_pkg::mix_group(base_hash, base_bytes[15:0],
                                        {key_byte_i, base_bytes[23:16]});
        next_bytes = '0;
      end
    endcase
  end

  // state returns to zero once a key is finished
  always_comb begin
    hash_d  = hash_q;
    bytes_d = bytes_q;
    pos_d   = pos_q;
    count_d = count_q;
    if (accept) begin
      if (last_byte_i) begin
        hash_d  = '0;
        bytes_d = '0;
        pos_d   = '0;
        count_d = '0;
      end else begin
        hash_d  = next_hash;
        bytes_d = next_bytes;
        pos_d   = next_pos;
        count_d = next_count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= '0;
      bytes_q <= '0;
      pos_q   <= '0;
      count_q <= '0;
      decl_q  <= '0;
    end else begin
      hash_q  <= hash_d;
      bytes_q <= bytes_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      if (accept) begin
        decl_q <= last_byte_i ? '0 : decl_d;
      end
    end
  end

  // finished key handed to the finishing pipeline
  assign tail_valid   = in_valid_i && last_byte_i;
  assign tail.hash    = next_hash;
  assign tail.bytes   = next_bytes;
  assign tail.pend    = next_pos;
  assign tail.len_err = (next_count != decl_d);
  assign tail.empty   = (decl_d == '0);

  sfh_finish u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tail_valid_i   (tail_valid),
    .tail_i         (tail),
    .tail_ready_o   (fin_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_value_o   (hash_value_o),
    .length_error_o (length_error_o)
  );

endmodule

FILE: sv/sfh_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfh_finish: finishing pipeline of the byte-stream hash
// Takes the state of a finished key, folds the tail, runs the avalanche over
// three stages and holds the result in an output register with stall.
// ----------------------------------------------------------------------------
module sfh_finish (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tail_valid_i,
  input  sfh_pkg::sfh_tail_t              tail_i,
  output logic                            tail_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sfh_pkg::HashW-1:0]       hash_value_o,
  output logic                            length_error_o
);

  logic                       v0_q, v1_q, v2_q, v3_q;
  logic                       en0, en1, en2, en3;
  logic [sfh_pkg::HashW-1:0]  h0_q, h1_q, h2_q, h3_q;
  logic [sfh_pkg::HashW-1:0]  h0_d, h1_d, h2_d, h3_d;
  logic                       err0_q, err1_q, err2_q, err3_q;
  logic                       emp0_q, emp1_q, emp2_q;

  // a stage loads when it is empty or its contents move on
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign tail_ready_o = en0;

  // per-stage hash logic
  assign h0_d = sfh_pkg::fold_tail(tail_i.hash, tail_i.pend, tail_i.bytes);
  assign h1_d = sfh_pkg::aval_a(h0_q);
  assign h2_d = sfh_pkg::aval_b(h1_q);
  assign h3_d = emp2_q ? '0 : sfh_pkg::aval_c(h2_q);

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= tail_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en0 && tail_valid_i) begin
      h0_q   <= h0_d;
      err0_q <= tail_i.len_err;
      emp0_q <= tail_i.empty;
    end
    if (en1 && v0_q) begin
      h1_q   <= h1_d;
      err1_q <= err0_q;
      emp1_q <= emp0_q;
    end
    if (en2 && v1_q) begin
      h2_q   <= h2_d;
      err2_q <= err1_q;
      emp2_q <= emp1_q;
    end
    if (en3 && v2_q) begin
      h3_q   <= h3_d;
      err3_q <= err2_q;
    end
  end

  assign out_valid_o    = v3_q;
  assign hash_value_o   = h3_q;
  assign length_error_o = err3_q;

endmodule

FILE: bench/tb_superfast_byte_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_superfast_byte_hash: self-checking bench for the streaming byte hash
// Feeds keys one byte per transfer through the valid/stall input channel,
// predicts each finished hash and length flag, and checks every output
// transfer in order against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_superfast_byte_hash;

  localparam int CycleLimit  = 500000;
  localparam int HoldCycles  = 300;
  localparam int RandomItems = 950;
  localparam int QuietItems  = 150;
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic [sfh_pkg::HashW-1:0] hash;
    logic                      len_err;
  } key_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [7:0]                  key_byte_i;
  logic [sfh_pkg::KeyLenW-1:0] key_length_i;
  logic                        first_byte_i;
  logic                        last_byte_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [sfh_pkg::HashW-1:0]   hash_value_o;
  logic                        length_error_o;

  // predicted hashes waiting for their output transfer
  key_result_t pending_hashes[$];

  // predictor copy of the running key state
  logic [31:0]                 hash_acc;
  logic [23:0]                 tail_bytes;
  logic [1:0]                  tail_count;
  logic [sfh_pkg::KeyLenW-1:0] bytes_seen;
  logic [sfh_pkg::KeyLenW-1:0] length_seen;

  int error_count = 0;
  int bytes_sent  = 0;
  int cycle_count = 0;
  bit idling      = 1'b0;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  superfast_byte_hash dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .key_byte_i     (key_byte_i),
    .key_length_i   (key_length_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_value_o   (hash_value_o),
    .length_error_o (length_error_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall: long hold-off on request, else random or none
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (idling) begin
      out_stall_i <= ($urandom_range(99) < 33);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    error_count++;
  endtask

  // compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    key_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected result hash %08h err %0b",
                                  hash_value_o, length_error_o));
      end else begin
        want = pending_hashes.pop_front();
        if (hash_value_o !== want.hash)
          report_mismatch($sformatf("hash_value got %08h want %08h",
                                    hash_value_o, want.hash));
        if (length_error_o !== want.len_err)
          report_mismatch($sformatf("length_error got %0b want %0b",
                                    length_error_o, want.len_err));
      end
    end
  end

  // advance the predicted key state by one accepted byte
  task automatic hash_key_byte(input logic [7:0] b, input logic [15:0] len,
                               input logic f, input logic l);
    logic [31:0] h;
    logic [31:0] t;
    logic [31:0] sx;
    key_result_t res;
    if (f) begin
      hash_acc    = {16'd0, len};
      length_seen = len;
      bytes_seen  = '0;
      tail_bytes  = '0;
      tail_count  = '0;
    end
    bytes_seen = bytes_seen + 1'b1;
    // full group: mix low and high halves little-endian
    if (tail_count == 2'd3) begin
      h = hash_acc + {16'd0, tail_bytes[15:0]};
      t = ({16'd0, b, tail_bytes[23:16]} << 11) ^ h;
      h = (h << 16) ^ t;
      hash_acc   = h + (h >> 11);
      tail_bytes = '0;
      tail_count = '0;
    end else begin
      tail_bytes[8*tail_count +: 8] = b;
      tail_count = tail_count + 1'b1;
    end
    if (l) begin
      h = hash_acc;
      // fold pending tail, odd byte sign-extended
      case (tail_count)
        2'd3: begin
          h  = h + {16'd0, tail_bytes[15:0]};
          h  = h ^ (h << 16);
          sx = {{24{tail_bytes[23]}}, tail_bytes[23:16]};
          h  = h ^ (sx << 18);
          h  = h + (h >> 11);
        end
        2'd2: begin
          h = h + {16'd0, tail_bytes[15:0]};
          h = h ^ (h << 11);
          h = h + (h >> 17);
        end
        2'd1: begin
          sx = {{24{tail_bytes[7]}}, tail_bytes[7:0]};
          h  = h + sx;
          h  = h ^ (h << 10);
          h  = h + (h >> 1);
        end
        default: begin
        end
      endcase
      // avalanche
      h = h ^ (h << 3);
      h = h + (h >> 5);
      h = h ^ (h << 4);
      h = h + (h >> 17);
      h = h ^ (h << 25);
      h = h + (h >> 6);
      res.hash    = (length_seen == '0) ? '0 : h;
      res.len_err = (bytes_seen != length_seen);
      pending_hashes.push_back(res);
      hash_acc    = '0;
      tail_bytes  = '0;
      tail_count  = '0;
      bytes_seen  = '0;
      length_seen = '0;
    end
  endtask

  // offer one byte, wait for its transfer, then predict
  task automatic send_byte(input logic [7:0] b, input logic [15:0] len,
                           input logic f, input logic l);
    while (idling && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    key_byte_i   <= b;
    key_length_i <= len;
    first_byte_i <= f;
    last_byte_i  <= l;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    hash_key_byte(b, len, f, l);
    bytes_sent++;
  endtask

  // a key of n random bytes, closed with a last mark when asked
  task automatic send_key(input logic [15:0] len, input int n, input bit close);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(255)), len, i == 0, close && (i == n - 1));
  endtask

  // stop offering and wait until every predicted result has come
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_hashes.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_edge_keys();
    // empty key still closed by one byte
    send_byte(8'h00, 16'd0, 1'b1, 1'b1);
    // one-byte keys, sign bit clear and set
    send_byte(8'hFF, 16'd1, 1'b1, 1'b1);
    send_byte(8'h7F, 16'd1, 1'b1, 1'b1);
    // two- and three-byte tails
    send_byte(8'hFF, 16'd2, 1'b1, 1'b0);
    send_byte(8'h80, 16'd2, 1'b0, 1'b1);
    send_byte(8'h12, 16'd3, 1'b1, 1'b0);
    send_byte(8'h34, 16'd3, 1'b0, 1'b0);
    send_byte(8'h80, 16'd3, 1'b0, 1'b1);
    // one full group of all ones
    for (int i = 0; i < 4; i++)
      send_byte(8'hFF, 16'd4, i == 0, i == 3);
    // all-ones declared length against five bytes
    for (int i = 0; i < 5; i++)
      send_byte(8'h00, 16'hFFFF, i == 0, i == 4);
    drain_results();
    // bytes with no first mark continue from the zero state
    send_byte(8'hA5, 16'h1234, 1'b0, 1'b0);
    send_byte(8'h5A, 16'h1234, 1'b0, 1'b1);
    // first mark mid-key drops the partial key
    send_byte(8'h01, 16'd3, 1'b1, 1'b0);
    send_byte(8'h02, 16'd3, 1'b0, 1'b0);
    send_byte(8'h03, 16'd2, 1'b1, 1'b0);
    send_byte(8'h04, 16'd2, 1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_output_hold_off();
    // receiver holds off while short keys keep coming
    idling = 1'b0;
    hold_req++;
    for (int i = 0; i < 40; i++) begin
      int n;
      n = $urandom_range(1, 3);
      send_key(16'(n), n, 1'b1);
    end
    drain_results();
    idling = 1'b1;
  endtask

  task automatic test_random_keys();
    int kind;
    int n;
    int quiet_end;
    quiet_end = bytes_sent + QuietItems;
    idling = 1'b0;
    while (bytes_sent < RandomItems) begin
      if (bytes_sent >= quiet_end) idling = 1'b1;
      kind = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (kind < 70) begin
        send_key(16'(n), n, 1'b1);
      end else if (kind < 80) begin
        send_key(16'($urandom_range(65535)), n, 1'b1);
      end else if (kind < 85) begin
        send_key(16'd0, n, 1'b1);
      end else if (kind < 92) begin
        // broken key, dropped by the next first mark
        send_key(16'(n), $urandom_range(1, 6), 1'b0);
      end else begin
        // orphan bytes with no first mark
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom_range(255)), 16'($urandom_range(65535)), 1'b0,
                    (i == n - 1) && ($urandom_range(1) == 1));
      end
    end
    drain_results();
  endtask

  // reset, tests in turn, final check
  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    key_byte_i   <= '0;
    key_length_i <= '0;
    first_byte_i <= 1'b0;
    last_byte_i  <= 1'b0;
    out_stall_i  <= 1'b0;
    hash_acc     = '0;
    tail_bytes   = '0;
    tail_count   = '0;
    bytes_seen   = '0;
    length_seen  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idling = 1'b1;
    test_edge_keys();
    test_output_hold_off();
    test_random_keys();
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_hashes.size() != 0)
      report_mismatch($sformatf("%0d results never came", pending_hashes.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/sfh_pkg.sv
sv/sfh_finish.sv
sv/superfast_byte_hash.sv
bench/tb_superfast_byte_hash.sv
